### src/rrqs_pkg.sv
package rrqs_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam logic [7:0] QUANTUM_RESET = 8'd10;

    localparam logic [1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [1:0] CMD_SPAWN    = 2'd1;
    localparam logic [1:0] CMD_SLEEP    = 2'd2;
    localparam logic [1:0] CMD_EXIT     = 2'd3;

    localparam logic [2:0] ST_FREE     = 3'd0;
    localparam logic [2:0] ST_SPAWNED  = 3'd1;
    localparam logic [2:0] ST_READY    = 3'd2;
    localparam logic [2:0] ST_RUNNING  = 3'd3;
    localparam logic [2:0] ST_SLEEPING = 3'd4;
    localparam logic [2:0] ST_DEAD     = 3'd5;

    localparam logic [1:0] OC_OK           = 2'd0;
    localparam logic [1:0] OC_EMPTY        = 2'd1;
    localparam logic [1:0] OC_NONE_RUNNABLE = 2'd2;
    localparam logic [1:0] OC_BAD_SLOT     = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  slot;
        logic [63:0] context_handle;
        logic [63:0] uptime;
        logic [63:0] wake_deadline;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  next_slot;
        logic [63:0] next_context;
        logic        switched;
        logic [1:0]  outcome;
    } rsp_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  quantum_left;
        logic [63:0] wake_at;
    } entry_t;

    typedef struct packed {
        logic        entry_en;
        logic        ctx_en;
        entry_t      entry;
        logic [63:0] ctx;
    } tbl_wr_t;

endpackage

### src/rrqs_slot_table.sv
module rrqs_slot_table #(
    parameter int TASK_SLOTS = rrqs_pkg::TASK_SLOTS_DEF,
    localparam int IDX_W = $clog2(TASK_SLOTS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output rrqs_pkg::entry_t     rd_entry,
    output logic [63:0]          rd_ctx,
    input  logic [IDX_W-1:0]     wr_addr,
    input  rrqs_pkg::tbl_wr_t    wr
);
    import rrqs_pkg::*;

    entry_t          entry_mem [TASK_SLOTS];
    logic [63:0]     ctx_mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] valid_reg;
    entry_t          entry_rd_reg;
    logic [63:0]     ctx_rd_reg;
    logic            hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.entry_en)
        begin
            entry_mem[wr_addr] <= wr.entry;
        end
        if (wr.ctx_en)
        begin
            ctx_mem[wr_addr] <= wr.ctx;
        end
        if (rd_en)
        begin
            entry_rd_reg <= entry_mem[rd_addr];
            ctx_rd_reg   <= ctx_mem[rd_addr];
        end
    end

    // An entry that has never been written reads as a free slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.entry_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = hit_reg ? entry_rd_reg : '0;
    assign rd_ctx   = ctx_rd_reg;

endmodule

### src/round_robin_quantum_scheduler.sv
// Spawn, sleep and exit: the entry is read on acceptance, written in the command state.
// Schedule: the scan visits one slot per cycle from the slot table memory, up to
// TASK_SLOTS+1 slots. Every result is registered from the output state.
// A new transaction is accepted while the previous result still waits to be taken.
// Reset is asynchronous and active low; the slot table reads as all free at once,
// with no clearing pass, and the quantum register returns to 10.
module round_robin_quantum_scheduler #(
    parameter int TASK_SLOTS = rrqs_pkg::TASK_SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  rrqs_pkg::cmd_t   cmd,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rrqs_pkg::rsp_t   rsp
);
    import rrqs_pkg::*;

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int SW = (IDX_W > 4) ? IDX_W : 4;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    logic [7:0]      quantum_reg, quantum_next;
    logic [IDX_W-1:0] cur_slot_reg, cur_slot_next;
    logic            cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W:0]  cnt_reg, cnt_next;
    logic            sw_reg, sw_next;
    logic            occ_reg, occ_next;
    rsp_t            res_reg, res_next;
    rsp_t            rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;

    logic            tbl_rd_en;
    logic [IDX_W-1:0] tbl_rd_addr;
    entry_t          tbl_rd_entry;
    logic [63:0]     tbl_rd_ctx;
    logic [IDX_W-1:0] tbl_wr_addr;
    tbl_wr_t         tbl_wr;

    logic [SW:0]     slot_in_wide;
    logic [SW:0]     slot_reg_wide;
    logic            slot_in_bad;
    logic            slot_reg_bad;
    logic [SW-1:0]   pos_wide;
    logic [IDX_W-1:0] pos_inc;
    logic            accept;

    function automatic logic is_occupied(input logic [2:0] st);
        return (st >= ST_SPAWNED) && (st <= ST_DEAD);
    endfunction

    assign slot_in_wide  = (SW+1)'(cmd.slot);
    assign slot_reg_wide = (SW+1)'(cmd_reg.slot);
    assign slot_in_bad   = slot_in_wide >= (SW+1)'(TASK_SLOTS);
    assign slot_reg_bad  = slot_reg_wide >= (SW+1)'(TASK_SLOTS);
    assign pos_wide      = SW'(pos_reg);
    assign pos_inc       = (pos_reg == IDX_W'(TASK_SLOTS - 1)) ? '0 : IDX_W'(pos_reg + 1'b1);
    assign accept        = cmd_valid && (state_reg == S_IDLE);

    rrqs_slot_table #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (tbl_rd_en),
        .rd_addr  (tbl_rd_addr),
        .rd_entry (tbl_rd_entry),
        .rd_ctx   (tbl_rd_ctx),
        .wr_addr  (tbl_wr_addr),
        .wr       (tbl_wr)
    );

    always_comb
    begin
        entry_t      ent;
        entry_t      wr_ent;
        logic [7:0]  q_dec;
        logic [63:0] ctx_out;
        logic        pick;
        logic        sw_all;
        logic        occ;
        logic        ok;

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        quantum_next   = cfg_wr_en ? cfg_wr_data : quantum_reg;
        cur_slot_next  = cur_slot_reg;
        cur_valid_next = cur_valid_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        sw_next        = sw_reg;
        occ_next       = occ_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        tbl_rd_en   = 1'b0;
        tbl_rd_addr = slot_in_wide[IDX_W-1:0];
        tbl_wr_addr = pos_reg;
        tbl_wr      = '0;

        ent     = tbl_rd_entry;
        wr_ent  = ent;
        q_dec   = (ent.quantum_left != 8'd0) ? ent.quantum_left - 8'd1 : 8'd0;
        ctx_out = tbl_rd_ctx;
        pick    = 1'b0;
        sw_all  = sw_reg;
        occ     = is_occupied(ent.status);
        ok      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd;
                    if (cmd.command == CMD_SCHEDULE)
                    begin
                        tbl_rd_en   = 1'b1;
                        tbl_rd_addr = cur_valid_reg ? cur_slot_reg : '0;
                        pos_next    = cur_valid_reg ? cur_slot_reg : '0;
                        cnt_next    = '0;
                        sw_next     = 1'b0;
                        occ_next    = 1'b0;
                        state_next  = S_SCAN;
                    end
                    else
                    begin
                        tbl_rd_en  = !slot_in_bad;
                        state_next = S_CMD;
                    end
                end
            end
            S_CMD:
            begin
                tbl_wr_addr = slot_reg_wide[IDX_W-1:0];
                case (cmd_reg.command)
                    CMD_SPAWN:
                    begin
                        ok = (ent.status == ST_FREE);
                        wr_ent.status       = ST_SPAWNED;
                        wr_ent.quantum_left = 8'd0;
                        wr_ent.wake_at      = '0;
                        tbl_wr.ctx_en       = ok && !slot_reg_bad;
                        tbl_wr.ctx          = cmd_reg.context_handle;
                    end
                    CMD_SLEEP:
                    begin
                        ok = occ && (ent.status != ST_DEAD);
                        wr_ent.status  = ST_SLEEPING;
                        wr_ent.wake_at = cmd_reg.wake_deadline;
                    end
                    CMD_EXIT:
                    begin
                        ok = occ;
                        wr_ent.status = ST_DEAD;
                    end
                    default:
                    begin
                        ok = 1'b0;
                    end
                endcase
                ok                    = ok && !slot_reg_bad;
                tbl_wr.entry_en       = ok;
                tbl_wr.entry          = wr_ent;
                res_next.next_slot    = 4'd0;
                res_next.next_context = '0;
                res_next.switched     = 1'b0;
                res_next.outcome      = ok ? OC_OK : OC_BAD_SLOT;
                state_next            = S_OUT;
            end
            S_SCAN:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = pos_inc;
                case (ent.status)
                    ST_SPAWNED, ST_READY:
                    begin
                        pick   = 1'b1;
                        sw_all = 1'b1;
                    end
                    ST_RUNNING:
                    begin
                        tbl_wr.ctx_en       = 1'b1;
                        tbl_wr.ctx          = cmd_reg.context_handle;
                        ctx_out             = cmd_reg.context_handle;
                        wr_ent.quantum_left = q_dec;
                        if (q_dec != 8'd0)
                        begin
                            pick = 1'b1;
                        end
                        else
                        begin
                            wr_ent.status   = ST_READY;
                            sw_all          = 1'b1;
                            tbl_wr.entry_en = 1'b1;
                        end
                    end
                    ST_SLEEPING:
                    begin
                        if (cmd_reg.uptime > ent.wake_at)
                        begin
                            pick           = 1'b1;
                            sw_all         = 1'b1;
                            wr_ent.wake_at = '0;
                        end
                    end
                    ST_DEAD:
                    begin
                        wr_ent          = '0;
                        tbl_wr.entry_en = 1'b1;
                        sw_all          = 1'b1;
                    end
                    default:
                    begin
                        pick = 1'b0;
                    end
                endcase

                if (pick)
                begin
                    wr_ent.status = ST_RUNNING;
                    if (sw_all)
                    begin
                        wr_ent.quantum_left = quantum_reg;
                    end
                    tbl_wr.entry_en       = 1'b1;
                    cur_slot_next         = pos_reg;
                    cur_valid_next        = 1'b1;
                    res_next.next_slot    = pos_wide[3:0];
                    res_next.next_context = ctx_out;
                    res_next.switched     = sw_all;
                    res_next.outcome      = OC_OK;
                    state_next            = S_OUT;
                end
                else if (cnt_reg == (IDX_W+1)'(TASK_SLOTS))
                begin
                    res_next.next_slot    = 4'd0;
                    res_next.next_context = '0;
                    res_next.switched     = 1'b0;
                    res_next.outcome      = (occ_reg || occ) ? OC_NONE_RUNNABLE : OC_EMPTY;
                    state_next            = S_OUT;
                end
                else
                begin
                    pos_next = pos_inc;
                    cnt_next = (IDX_W+1)'(cnt_reg + 1'b1);
                    sw_next  = sw_all;
                    occ_next = occ_reg || occ;
                end
                tbl_wr.entry = wr_ent;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            quantum_reg   <= QUANTUM_RESET;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            sw_reg        <= 1'b0;
            occ_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quantum_reg   <= quantum_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            sw_reg        <= sw_next;
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_current_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |=> cur_valid_reg)
        else $error("current task flag dropped");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");

    a_switch_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.switched) |-> (rsp_reg.outcome == OC_OK))
        else $error("switch reported with a failing outcome");

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_rd_en && (tbl_wr.entry_en || tbl_wr.ctx_en)) |-> (tbl_rd_addr != tbl_wr_addr))
        else $error("slot table read and write hit the same entry");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= (IDX_W+1)'(TASK_SLOTS)))
        else $error("scan ran past a full pass");

endmodule
